/* sv/tccw_pkg.sv */
package tccw_pkg;

  // Item function codes; the last one is a no-op that still reports the cursor
  typedef enum logic [1:0] {
    FN_PUT   = 2'd0,
    FN_READ  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NOP   = 2'd3
  } func_e;

  // Character codes with special handling
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;

  // Cell contents: attribute in the high byte, character in the low byte
  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  TEXT_ATTR  = 8'h07;
  localparam int          TAB_STOP   = 8;

  // Cell update request from the cursor logic
  typedef struct packed {
    logic wr;      // write one cell
    logic blank;   // write a blank instead of the character
    logic scroll;  // cursor ran off the last row
  } put_ctl_t;

  // One result word
  typedef struct packed {
    logic [15:0] read_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } rsp_word_t;

endpackage

/* sv/tccw_if.sv */
// Request channel: one console command per word
interface tccw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  ch;
  logic [10:0] cell_index;

  modport source (output valid, output func, output ch, output cell_index, input ready);
  modport sink   (input valid, input func, input ch, input cell_index, output ready);
endinterface

// Response channel: one result word per command
interface tccw_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;

  modport source (output valid, output read_data, output cursor_col, output cursor_row,
                  input ready);
  modport sink   (input valid, input read_data, input cursor_col, input cursor_row,
                  output ready);
endinterface

/* sv/text_console_char_writer_core.sv */
// Text console with a COLUMNS x ROWS screen of 16-bit cells (attribute high byte,
// character low byte) and a cursor, held in one single-port-write, single-port-read
// memory. Every command returns exactly one result word with the cursor after the
// command. A put character that does not scroll, and a no-op, finish in the idle
// state, so a new command can be taken every cycle while the output register is free;
// a cell read goes through a read-data state for the registered memory read. A scroll
// or a clear sweeps the whole memory one cell per cycle through a read-then-write
// pipeline that copies rows up on a scroll and writes blanks on a clear. After reset
// the same sweep blanks the screen, and no command is accepted until it ends. A
// finished result waits in the output register while the next command is worked on;
// one more result is held in a spare register before the request side stalls.
module text_console_char_writer_core import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tccw_req_if.sink       req_i,
  tccw_rsp_if.source     rsp_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RDATA,
    ST_HOLD
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          copy_q, copy_d;
  logic          emit_q, emit_d;
  logic          wp_vld_q, wp_vld_d;
  logic [AW-1:0] wp_addr_q, wp_addr_d;
  logic          wp_mem_q, wp_mem_d;
  logic          rd_ok_q, rd_ok_d;
  logic          out_vld_q, out_vld_d;
  rsp_word_t     out_q, out_d;
  rsp_word_t     pend_q, pend_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;

  logic [CW-1:0] calc_col;
  logic [RW-1:0] calc_row;
  logic [AW-1:0] calc_addr;
  put_ctl_t      calc_ctl;

  logic          req_acc;
  logic          out_free;
  logic          fin;
  logic          copy_rd;
  rsp_word_t     res;

  tccw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tccw_cursor_calc #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_calc (
    .col_i  (col_q),
    .row_i  (row_q),
    .ch_i   (req_i.ch),
    .col_o  (calc_col),
    .row_o  (calc_row),
    .addr_o (calc_addr),
    .ctl_o  (calc_ctl)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || rsp_o.ready;
  // sweep reads the row below while it is still inside the copied region
  assign copy_rd     = copy_q && (ptr_q < COPY_END);

  // Sequencer, memory access and result assembly
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    ptr_d     = ptr_q;
    copy_d    = copy_q;
    emit_d    = emit_q;
    wp_vld_d  = 1'b0;
    wp_addr_d = wp_addr_q;
    wp_mem_d  = wp_mem_q;
    rd_ok_d   = rd_ok_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    out_d     = out_q;
    pend_d    = pend_q;
    fin       = 1'b0;
    res       = '0;
    mem_re    = 1'b0;
    mem_raddr = AW'(req_i.cell_index);
    // sweep write stage owns the write port while it runs
    mem_we    = wp_vld_q;
    mem_waddr = wp_addr_q;
    mem_wdata = wp_mem_q ? mem_rdata : BLANK_CELL;

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (func_e'(req_i.func))
            FN_PUT: begin
              col_d = calc_col;
              row_d = calc_row;
              if (calc_ctl.wr) begin
                mem_we    = 1'b1;
                mem_waddr = calc_addr;
                mem_wdata = calc_ctl.blank ? BLANK_CELL : {TEXT_ATTR, req_i.ch};
              end
              if (calc_ctl.scroll) begin
                state_d = ST_SWEEP;
                ptr_d   = '0;
                copy_d  = 1'b1;
                emit_d  = 1'b1;
              end else begin
                fin            = 1'b1;
                res.cursor_col = 7'(calc_col);
                res.cursor_row = 5'(calc_row);
              end
            end
            FN_READ: begin
              mem_re  = 1'b1;
              rd_ok_d = (32'(req_i.cell_index) < CELLS);
              state_d = ST_RDATA;
            end
            FN_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              state_d = ST_SWEEP;
              ptr_d   = '0;
              copy_d  = 1'b0;
              emit_d  = 1'b1;
            end
            default: begin
              fin            = 1'b1;
              res.cursor_col = 7'(col_q);
              res.cursor_row = 5'(row_q);
            end
          endcase
        end
      end
      ST_RDATA: begin
        fin            = 1'b1;
        res.read_data  = rd_ok_q ? mem_rdata : 16'h0000;
        res.cursor_col = 7'(col_q);
        res.cursor_row = 5'(row_q);
      end
      ST_SWEEP: begin
        mem_re    = copy_rd;
        mem_raddr = ptr_q + AW'(COLUMNS);
        wp_vld_d  = 1'b1;
        wp_addr_d = ptr_q;
        wp_mem_d  = copy_rd;
        if (ptr_q == LAST_CELL) begin
          state_d = ST_DRAIN;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        // last sweep write lands this cycle
        if (emit_q) begin
          fin            = 1'b1;
          res.cursor_col = 7'(col_q);
          res.cursor_row = 5'(row_q);
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d     = pend_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // finished result goes to the output register, or waits in the spare one
    if (fin) begin
      if (out_free) begin
        out_d     = res;
        out_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end else begin
        pend_d  = res;
        state_d = ST_HOLD;
      end
    end
  end

  // State and registered outputs; reset starts the blanking sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      col_q     <= '0;
      row_q     <= '0;
      ptr_q     <= '0;
      copy_q    <= 1'b0;
      emit_q    <= 1'b0;
      wp_vld_q  <= 1'b0;
      wp_addr_q <= '0;
      wp_mem_q  <= 1'b0;
      rd_ok_q   <= 1'b0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
      pend_q    <= '0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      ptr_q     <= ptr_d;
      copy_q    <= copy_d;
      emit_q    <= emit_d;
      wp_vld_q  <= wp_vld_d;
      wp_addr_q <= wp_addr_d;
      wp_mem_q  <= wp_mem_d;
      rd_ok_q   <= rd_ok_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
      pend_q    <= pend_d;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.read_data  = out_q.read_data;
  assign rsp_o.cursor_col = out_q.cursor_col;
  assign rsp_o.cursor_row = out_q.cursor_row;

endmodule

/* sv/tccw_screen_ram.sv */
// Screen cell store: one write port, one read port, registered read data
module tccw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* sv/tccw_cursor_calc.sv */
// Cursor movement and cell write for one put-character command
module tccw_cursor_calc import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CW     = $clog2(COLUMNS),
  localparam int RW     = $clog2(ROWS),
  localparam int AW     = $clog2(COLUMNS * ROWS)
) (
  input  logic [CW-1:0] col_i,
  input  logic [RW-1:0] row_i,
  input  logic [7:0]    ch_i,
  output logic [CW-1:0] col_o,
  output logic [RW-1:0] row_o,
  output logic [AW-1:0] addr_o,
  output put_ctl_t      ctl_o
);

  logic [CW:0]   col_inc;
  logic [CW:0]   col_tab;
  logic [CW-1:0] wcol;
  logic [RW-1:0] wrow;
  logic          nl;

  // One extra bit so that reaching the right edge is visible
  assign col_inc = {1'b0, col_i} + (CW+1)'(1);
  assign col_tab = ({1'b0, col_i} + (CW+1)'(TAB_STOP)) & ~(CW+1)'(TAB_STOP - 1);

  always_comb begin
    col_o = col_i;
    row_o = row_i;
    wcol  = col_i;
    wrow  = row_i;
    ctl_o = '0;
    nl    = 1'b0;
    case (ch_i)
      CH_LF: nl = 1'b1;
      CH_CR: col_o = '0;
      CH_BS: begin
        if (col_i != '0) begin
          col_o = col_i - CW'(1);
        end else if (row_i != '0) begin
          row_o = row_i - RW'(1);
          col_o = CW'(COLUMNS - 1);
        end
        // blank the cell under the new position
        wcol        = col_o;
        wrow        = row_o;
        ctl_o.wr    = 1'b1;
        ctl_o.blank = 1'b1;
      end
      CH_TAB: begin
        if (col_tab >= (CW+1)'(COLUMNS)) begin
          nl = 1'b1;
        end else begin
          col_o = col_tab[CW-1:0];
        end
      end
      default: begin
        if (ch_i inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
          ctl_o.wr = 1'b1;
          if (col_inc == (CW+1)'(COLUMNS)) begin
            nl = 1'b1;
          end else begin
            col_o = col_inc[CW-1:0];
          end
        end
      end
    endcase
    // next line; at the bottom row the screen scrolls and the row stays
    if (nl) begin
      col_o = '0;
      if (row_i == RW'(ROWS - 1)) begin
        ctl_o.scroll = 1'b1;
      end else begin
        row_o = row_i + RW'(1);
      end
    end
  end

  assign addr_o = AW'(wrow) * AW'(COLUMNS) + AW'(wcol);

endmodule

/* sv/tccw_checker.sv */
// Port-level checks of the console core
module tccw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [15:0] rsp_read_data_i,
  input logic [6:0]  rsp_cursor_col_i,
  input logic [4:0]  rsp_cursor_row_i
);

  logic       req_acc;
  logic       rsp_acc;
  logic [1:0] outst_q;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // commands taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_q + 2'(req_acc) - 2'(rsp_acc);
    end
  end

  // reported column always lies on the screen
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (32'(rsp_cursor_col_i) < COLUMNS))
    else $error("cursor column off screen");

  // reported row always lies on the screen
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (32'(rsp_cursor_row_i) < ROWS))
    else $error("cursor row off screen");

  // no result without a command waiting for it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (outst_q != 2'd0))
    else $error("result without a pending command");

  // at most one result in the output register and one held behind it
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outst_q == 2'd2) |-> !req_ready_i)
    else $error("command accepted with two results pending");

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_read_data_i)
      && $stable(rsp_cursor_col_i) && $stable(rsp_cursor_row_i)))
    else $error("stalled result changed");

endmodule

bind text_console_char_writer_core tccw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_read_data_i  (rsp_o.read_data),
  .rsp_cursor_col_i (rsp_o.cursor_col),
  .rsp_cursor_row_i (rsp_o.cursor_row)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top import tccw_pkg::*;;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int RANDOM_WORDS = 1450;
  localparam int PHASES       = 3;
  localparam int IDLE_PCT     = 11;

  // One console command as queued for the driver
  typedef struct {
    func_e       func;
    logic [7:0]  ch;
    logic [10:0] cell_index;
    bit          drain;   // hold off until every result is back
  } console_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tccw_req_if req_bus ();
  tccw_rsp_if rsp_bus ();

  text_console_char_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always #4 clk_i = ~clk_i;

  console_cmd_t pending_cmds[$];
  rsp_word_t    expected_words[$];
  int           mismatch_count;
  int           cmds_accepted;
  bit           cmd_taken;

  // Shadow of the screen and cursor
  logic [15:0] shadow_screen [CELLS];
  int          shadow_col;
  int          shadow_row;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic console_blank();
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = BLANK_CELL;
    shadow_col = 0;
    shadow_row = 0;
  endtask

  // Move every row up by one and blank the bottom row
  task automatic console_scroll();
    for (int i = 0; i + COLUMNS < CELLS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_screen[i] = BLANK_CELL;
    shadow_row = ROWS - 1;
  endtask

  task automatic console_newline();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS) console_scroll();
  endtask

  task automatic console_put(input logic [7:0] ch);
    if (ch == CH_LF) begin
      console_newline();
    end else if (ch == CH_CR) begin
      shadow_col = 0;
    end else if (ch == CH_BS) begin
      // step back, wrapping to the previous row; top-left stays put
      if (shadow_col > 0) begin
        shadow_col--;
      end else if (shadow_row > 0) begin
        shadow_row--;
        shadow_col = COLUMNS - 1;
      end
      shadow_screen[shadow_row * COLUMNS + shadow_col] = BLANK_CELL;
    end else if (ch == CH_TAB) begin
      shadow_col = (shadow_col + TAB_STOP) & ~(TAB_STOP - 1);
      if (shadow_col >= COLUMNS) console_newline();
    end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
      shadow_screen[shadow_row * COLUMNS + shadow_col] = {TEXT_ATTR, ch};
      shadow_col++;
      if (shadow_col >= COLUMNS) console_newline();
    end
  endtask

  // Apply one command to the shadow and form the result word it should give
  task automatic console_apply(input func_e fn, input logic [7:0] ch,
                               input logic [10:0] idx, output rsp_word_t word);
    word.read_data = '0;
    case (fn)
      FN_PUT:   console_put(ch);
      FN_READ:  if (int'(idx) < CELLS) word.read_data = shadow_screen[idx];
      FN_CLEAR: console_blank();
      default: ;
    endcase
    word.cursor_col = 7'(shadow_col);
    word.cursor_row = 5'(shadow_row);
  endtask

  task automatic queue_cmd(input func_e fn, input logic [7:0] ch,
                           input logic [10:0] idx, input bit drain);
    console_cmd_t c;
    c.func       = fn;
    c.ch         = ch;
    c.cell_index = idx;
    c.drain      = drain;
    pending_cmds.push_back(c);
  endtask

  // Random command: mostly text, with enough newlines to keep scrolling
  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int pick;
    int sub;
    c.func       = FN_PUT;
    c.ch         = 8'($urandom_range(0, 255));
    c.cell_index = 11'($urandom_range(0, 2047));
    c.drain      = 1'b0;
    pick = $urandom_range(0, 999);
    if (pick < 2) begin
      c.func = FN_CLEAR;
    end else if (pick < 12) begin
      c.func = FN_NOP;
    end else if (pick < 200) begin
      c.func = FN_READ;
      sub = $urandom_range(0, 99);
      if (sub < 5)       c.cell_index = 11'($urandom_range(CELLS, 2047));
      else if (sub < 40) c.cell_index = 11'($urandom_range(CELLS - 5 * COLUMNS, CELLS - 1));
      else               c.cell_index = 11'($urandom_range(0, CELLS - 1));
    end else begin
      sub = $urandom_range(0, 99);
      if (sub < 12)      c.ch = CH_LF;
      else if (sub < 16) c.ch = CH_CR;
      else if (sub < 23) c.ch = CH_BS;
      else if (sub < 31) c.ch = CH_TAB;
      else if (sub < 36) begin
        // bytes the console ignores
        do begin
          c.ch = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(127, 255))
                                             : 8'($urandom_range(0, 31));
        end while (c.ch == CH_LF || c.ch == CH_CR || c.ch == CH_BS || c.ch == CH_TAB);
      end else begin
        c.ch = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
      end
    end
    return c;
  endfunction

  // Request driver: presents the head of the queue, idling at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_bus.valid || cmd_taken) begin
        cmd_taken = 1'b0;
        if (pending_cmds.size() == 0 ||
            (pending_cmds[0].drain && expected_words.size() != 0) ||
            (!(cmds_accepted >= 500 && cmds_accepted < 800) &&
             $urandom_range(0, 99) < IDLE_PCT)) begin
          req_bus.valid <= 1'b0;
        end else begin
          req_bus.valid      <= 1'b1;
          req_bus.func       <= pending_cmds[0].func;
          req_bus.ch         <= pending_cmds[0].ch;
          req_bus.cell_index <= pending_cmds[0].cell_index;
        end
      end
    end
  end

  // Response sink: stalls at random outside the stretch of accepted commands 500 to 799
  always @(negedge clk_i) begin
    rsp_bus.ready <= rst_ni && ((cmds_accepted >= 500 && cmds_accepted < 800) ||
                                $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Accepted command: update the shadow and queue the expected word
  always @(posedge clk_i) begin
    rsp_word_t word;
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      console_apply(func_e'(req_bus.func), req_bus.ch, req_bus.cell_index, word);
      expected_words.push_back(word);
      void'(pending_cmds.pop_front());
      cmds_accepted++;
      cmd_taken = 1'b1;
    end
  end

  // Result monitor: compare each word with the oldest expectation
  always @(posedge clk_i) begin
    rsp_word_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%h col=%0d row=%0d",
                                  rsp_bus.read_data, rsp_bus.cursor_col,
                                  rsp_bus.cursor_row));
      end else begin
        want = expected_words.pop_front();
        if (rsp_bus.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h, want %h",
                                    rsp_bus.read_data, want.read_data));
        if (rsp_bus.cursor_col !== want.cursor_col)
          report_mismatch($sformatf("cursor_col %0d, want %0d",
                                    rsp_bus.cursor_col, want.cursor_col));
        if (rsp_bus.cursor_row !== want.cursor_row)
          report_mismatch($sformatf("cursor_row %0d, want %0d",
                                    rsp_bus.cursor_row, want.cursor_row));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int counted;
    console_cmd_t c;
    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.func       = FN_NOP;
    req_bus.ch         = '0;
    req_bus.cell_index = '0;
    rsp_bus.ready      = 1'b0;
    mismatch_count     = 0;
    cmds_accepted      = 0;
    cmd_taken          = 1'b0;
    console_blank();

    // directed: extremes, ignored bytes, cursor wraps, reads out of range
    queue_cmd(FN_READ,  8'd0,        11'd0,    1'b0);
    queue_cmd(FN_PUT,   CH_PRINT_LO, 11'd2047, 1'b0);
    queue_cmd(FN_PUT,   CH_PRINT_HI, 11'd0,    1'b0);
    queue_cmd(FN_PUT,   8'd127,      11'd0,    1'b0);
    queue_cmd(FN_PUT,   8'd255,      11'd0,    1'b0);
    queue_cmd(FN_PUT,   8'd0,        11'd0,    1'b0);
    queue_cmd(FN_PUT,   8'd65,       11'd0,    1'b0);
    queue_cmd(FN_PUT,   CH_BS,       11'd0,    1'b0);
    queue_cmd(FN_PUT,   CH_CR,       11'd0,    1'b0);
    queue_cmd(FN_PUT,   CH_BS,       11'd0,    1'b0);   // top-left backspace
    queue_cmd(FN_READ,  8'd0,        11'd0,    1'b0);
    queue_cmd(FN_READ,  8'd0,        11'd1,    1'b0);
    queue_cmd(FN_PUT,   CH_TAB,      11'd0,    1'b0);
    queue_cmd(FN_PUT,   CH_LF,       11'd0,    1'b0);
    queue_cmd(FN_PUT,   CH_BS,       11'd0,    1'b0);   // wraps to end of row 0
    queue_cmd(FN_PUT,   8'd90,       11'd0,    1'b0);   // last column, wraps down
    queue_cmd(FN_READ,  8'd0,        11'd79,   1'b0);
    queue_cmd(FN_READ,  8'd255,      11'(CELLS - 1), 1'b0);
    queue_cmd(FN_READ,  8'd0,        11'(CELLS), 1'b0);
    queue_cmd(FN_READ,  8'd0,        11'd2047, 1'b0);
    queue_cmd(FN_NOP,   8'd255,      11'd2047, 1'b0);
    queue_cmd(FN_CLEAR, 8'd0,        11'd0,    1'b1);
    queue_cmd(FN_READ,  8'd0,        11'd0,    1'b0);

    // random phases; every phase but the first opens with a clear after the pipeline drains
    counted = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) queue_cmd(FN_CLEAR, 8'($urandom_range(0, 255)), 11'd0, 1'b1);
      while (counted < (ph + 1) * RANDOM_WORDS / PHASES) begin
        c = random_cmd();
        pending_cmds.push_back(c);
        counted++;
      end
    end

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #80_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
sv/tccw_pkg.sv
sv/tccw_if.sv
sv/tccw_screen_ram.sv
sv/tccw_cursor_calc.sv
sv/text_console_char_writer_core.sv
sv/tccw_checker.sv
verif/tb_top.sv
